// ----- rtl/v2d_pkg.sv -----
// Shared types and constants for the 2D vector arithmetic unit.
// No dependencies; imported by every module of the block.
package v2d_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int QUEUE_DEPTH   = 4;
  localparam int ROOT_W        = 32;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_SUB    = 3'd1;
  localparam logic [2:0] OP_SCALE  = 3'd2;
  localparam logic [2:0] OP_LENGTH = 3'd3;
  localparam logic [2:0] OP_NORM   = 3'd4;

  typedef enum logic [2:0] {
    K_ADD,
    K_SUB,
    K_SCALE,
    K_LEN,
    K_NORM,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] factor;
  } item_t;

  // Per-item payload carried down the back pipeline.
  typedef struct packed {
    kind_t              kind;
    logic [31:0]        ux;
    logic [31:0]        uy;
    logic               sx;
    logic               sy;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic               sat;
  } carry_t;

  function automatic kind_t decode_op(input logic [2:0] op);
    kind_t k;
    unique case (op)
      OP_ADD:    k = K_ADD;
      OP_SUB:    k = K_SUB;
      OP_SCALE:  k = K_SCALE;
      OP_LENGTH: k = K_LEN;
      OP_NORM:   k = K_NORM;
      default:   k = K_NOP;
    endcase
    return k;
  endfunction

endpackage

// ----- rtl/v2d_front.sv -----
// Front end: registers an incoming request and classifies its opcode.
// Depends on v2d_pkg.
module v2d_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [159:0]   s_tdata,
  input  logic [2:0]     s_tuser,
  output logic           q_valid,
  input  logic           q_ready,
  output v2d_pkg::item_t q_item
);
  import v2d_pkg::*;

  logic  valid;
  item_t item;

  assign s_tready = !valid || q_ready;
  assign q_valid  = valid;
  assign q_item   = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.kind   <= decode_op(s_tuser);
      item.a_x    <= s_tdata[31:0];
      item.a_y    <= s_tdata[63:32];
      item.b_x    <= s_tdata[95:64];
      item.b_y    <= s_tdata[127:96];
      item.factor <= s_tdata[159:128];
    end
  end

endmodule

// ----- rtl/v2d_queue.sv -----
// Short register queue between the front end and the execution pipeline.
// Depends on v2d_pkg.
module v2d_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  v2d_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output v2d_pkg::item_t out_item
);
  import v2d_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  item_t       mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          push;
  logic          pop;

  assign in_ready  = (count != (PW+1)'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_item  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

endmodule

// ----- rtl/v2d_back.sv -----
// Execution pipeline: add/sub/scale, square root by one bit per stage,
// restoring division by one quotient bit per stage. Depends on v2d_pkg.
module v2d_back #(
  parameter int FRAC_BITS = v2d_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  v2d_pkg::item_t in_item,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [95:0]    m_tdata,
  output logic [1:0]     m_tuser
);
  import v2d_pkg::*;

  localparam int QW = FRAC_BITS + 1;

  typedef struct packed {
    carry_t             c;
    logic signed [63:0] px;
    logic signed [63:0] py;
    logic [63:0]        sqx;
    logic [63:0]        sqy;
  } s1_t;

  typedef struct packed {
    carry_t      c;
    logic [63:0] n;
  } s2_t;

  typedef struct packed {
    carry_t      c;
    logic [63:0] n;
    logic [34:0] rem;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    carry_t        c;
    logic [31:0]   mag;
    logic [32:0]   remx;
    logic [32:0]   remy;
    logic [QW-1:0] qx;
    logic [QW-1:0] qy;
  } dv_t;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign in_ready = en;

  // Stage A: operand prep, add/sub with clamp, multipliers.
  s1_t         s1;
  logic        s1_v;
  carry_t      ca;
  logic [32:0] sum_x;
  logic [32:0] sum_y;

  always_comb begin
    ca      = '0;
    ca.kind = in_item.kind;
    ca.sx   = in_item.a_x[31];
    ca.sy   = in_item.a_y[31];
    ca.ux   = in_item.a_x[31] ? 32'(-in_item.a_x) : 32'(in_item.a_x);
    ca.uy   = in_item.a_y[31] ? 32'(-in_item.a_y) : 32'(in_item.a_y);
    if (in_item.kind == K_SUB) begin
      sum_x = {in_item.a_x[31], in_item.a_x} - {in_item.b_x[31], in_item.b_x};
      sum_y = {in_item.a_y[31], in_item.a_y} - {in_item.b_y[31], in_item.b_y};
    end else begin
      sum_x = {in_item.a_x[31], in_item.a_x} + {in_item.b_x[31], in_item.b_x};
      sum_y = {in_item.a_y[31], in_item.a_y} + {in_item.b_y[31], in_item.b_y};
    end
    ca.rx  = (sum_x[32] != sum_x[31]) ? {sum_x[32], {31{!sum_x[32]}}} : sum_x[31:0];
    ca.ry  = (sum_y[32] != sum_y[31]) ? {sum_y[32], {31{!sum_y[32]}}} : sum_y[31:0];
    ca.sat = (sum_x[32] != sum_x[31]) || (sum_y[32] != sum_y[31]);
  end

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (en) s1_v <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1.c   <= ca;
      s1.px  <= 64'(in_item.a_x) * 64'(in_item.factor);
      s1.py  <= 64'(in_item.a_y) * 64'(in_item.factor);
      s1.sqx <= 64'(ca.ux) * 64'(ca.ux);
      s1.sqy <= 64'(ca.uy) * 64'(ca.uy);
    end
  end

  // Stage B: scale rounding and clamp, sum of squares.
  s2_t                s2;
  logic               s2_v;
  carry_t             cb;
  logic signed [63:0] shx;
  logic signed [63:0] shy;
  logic               ovx;
  logic               ovy;

  always_comb begin
    cb  = s1.c;
    shx = s1.px >>> FRAC_BITS;
    shy = s1.py >>> FRAC_BITS;
    ovx = (shx[63:31] != '0) && (shx[63:31] != '1);
    ovy = (shy[63:31] != '0) && (shy[63:31] != '1);
    if (s1.c.kind == K_SCALE) begin
      cb.rx  = ovx ? {shx[63], {31{!shx[63]}}} : shx[31:0];
      cb.ry  = ovy ? {shy[63], {31{!shy[63]}}} : shy[31:0];
      cb.sat = ovx || ovy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (en) s2_v <= s1_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2.c <= cb;
      s2.n <= s1.sqx + s1.sqy;
    end
  end

  // Square root, one result bit per stage.
  sq_t  sq   [ROOT_W];
  logic sq_v [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    carry_t      c_in;
    logic [63:0] n_in;
    logic [34:0] rem_in;
    logic [31:0] root_in;
    logic        v_in;
    logic [34:0] cur;
    logic [34:0] trial;

    if (i == 0) begin : g_first
      assign c_in    = s2.c;
      assign n_in    = s2.n;
      assign rem_in  = '0;
      assign root_in = '0;
      assign v_in    = s2_v;
    end else begin : g_rest
      assign c_in    = sq[i-1].c;
      assign n_in    = sq[i-1].n;
      assign rem_in  = sq[i-1].rem;
      assign root_in = sq[i-1].root;
      assign v_in    = sq_v[i-1];
    end

    assign cur   = {rem_in[32:0], n_in[63-2*i -: 2]};
    assign trial = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) sq_v[i] <= 1'b0;
      else if (en) sq_v[i] <= v_in;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq[i].c <= c_in;
        sq[i].n <= n_in;
        if (cur >= trial) begin
          sq[i].rem  <= cur - trial;
          sq[i].root <= {root_in[30:0], 1'b1};
        end else begin
          sq[i].rem  <= cur;
          sq[i].root <= {root_in[30:0], 1'b0};
        end
      end
    end
  end

  // Restoring division |c| << FRAC_BITS / mag, one quotient bit per stage.
  dv_t  dv   [QW];
  logic dv_v [QW];

  for (genvar k = 0; k < QW; k++) begin : g_div
    carry_t        c_in;
    logic [31:0]   mag_in;
    logic [32:0]   rx_in;
    logic [32:0]   ry_in;
    logic [QW-1:0] qx_in;
    logic [QW-1:0] qy_in;
    logic          v_in;
    logic [32:0]   curx;
    logic [32:0]   cury;
    logic [32:0]   dvs;

    if (k == 0) begin : g_first
      assign c_in   = sq[ROOT_W-1].c;
      assign mag_in = sq[ROOT_W-1].root;
      assign rx_in  = {1'b0, sq[ROOT_W-1].c.ux};
      assign ry_in  = {1'b0, sq[ROOT_W-1].c.uy};
      assign qx_in  = '0;
      assign qy_in  = '0;
      assign v_in   = sq_v[ROOT_W-1];
      assign curx   = rx_in;
      assign cury   = ry_in;
    end else begin : g_rest
      assign c_in   = dv[k-1].c;
      assign mag_in = dv[k-1].mag;
      assign rx_in  = dv[k-1].remx;
      assign ry_in  = dv[k-1].remy;
      assign qx_in  = dv[k-1].qx;
      assign qy_in  = dv[k-1].qy;
      assign v_in   = dv_v[k-1];
      // remainder stays below the divisor, so the shift never drops a one
      assign curx   = {rx_in[31:0], 1'b0};
      assign cury   = {ry_in[31:0], 1'b0};
    end

    assign dvs = {1'b0, mag_in};

    always_ff @(posedge clk) begin
      if (rst) dv_v[k] <= 1'b0;
      else if (en) dv_v[k] <= v_in;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[k].c    <= c_in;
        dv[k].mag  <= mag_in;
        dv[k].remx <= (curx >= dvs) ? curx - dvs : curx;
        dv[k].remy <= (cury >= dvs) ? cury - dvs : cury;
        dv[k].qx   <= {qx_in[QW-2:0], curx >= dvs};
        dv[k].qy   <= {qy_in[QW-2:0], cury >= dvs};
      end
    end
  end

  // Result select and output register.
  dv_t         fin;
  logic [31:0] qx32;
  logic [31:0] qy32;
  logic [31:0] o_rx;
  logic [31:0] o_ry;
  logic [31:0] o_mag;
  logic        o_sat;
  logic        o_zero;

  assign fin  = dv[QW-1];
  assign qx32 = 32'(fin.qx);
  assign qy32 = 32'(fin.qy);

  always_comb begin
    o_rx   = '0;
    o_ry   = '0;
    o_mag  = '0;
    o_sat  = 1'b0;
    o_zero = 1'b0;
    unique case (fin.c.kind)
      K_ADD, K_SUB, K_SCALE: begin
        o_rx  = fin.c.rx;
        o_ry  = fin.c.ry;
        o_sat = fin.c.sat;
      end
      K_LEN: begin
        o_mag = fin.mag;
      end
      K_NORM: begin
        o_mag = fin.mag;
        if (fin.mag == '0) begin
          o_zero = 1'b1;
        end else begin
          o_rx = fin.c.sx ? -qx32 : qx32;
          o_ry = fin.c.sy ? -qy32 : qy32;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= dv_v[QW-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {o_mag, o_ry, o_rx};
      m_tuser <= {o_zero, o_sat};
    end
  end

endmodule

// ----- rtl/vector2d_arith_unit.sv -----
// 2D vector arithmetic unit, Q format fixed point, top level.
// Path from input accept to result: front register, queue, operand/multiply,
// square root and divide stages (both fully pipelined), output register.
// Throughput: one item per cycle unless the output is stalled by m_tready.
// Reset (rst, synchronous) clears all valid bits and the queue; no clearing pass.
// Depends on v2d_pkg, v2d_front, v2d_queue, v2d_back.
module vector2d_arith_unit #(
  parameter int FRAC_BITS = v2d_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [159:0] s_tdata,   // a_x, a_y, b_x, b_y, factor
  input  logic [2:0]   s_tuser,   // op
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,   // r_x, r_y, magnitude
  output logic [1:0]   m_tuser    // saturated, zero_length
);
  import v2d_pkg::*;

  logic  f_valid;
  logic  f_ready;
  item_t f_item;
  logic  b_valid;
  logic  b_ready;
  item_t b_item;

  v2d_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (f_valid),
    .q_ready  (f_ready),
    .q_item   (f_item)
  );

  v2d_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_item  (b_item)
  );

  v2d_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (b_valid),
    .in_ready (b_ready),
    .in_item  (b_item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ----- verif/vector2d_arith_unit_test.sv -----
// Self-checking testbench for vector2d_arith_unit: a directed table, then random requests.
// Depends on v2d_pkg (opcodes) and the DUT; checked against table values or an in-file predictor.
module vector2d_arith_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import v2d_pkg::*;

  localparam int FB = 16;
  localparam int LATENCY = FB + 38;
  localparam int N_RANDOM = 1750;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] factor;
  } vec_req_t;

  typedef struct packed {
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic [31:0]        magnitude;
    logic               saturated;
    logic               zero_length;
  } vec_res_t;

  typedef struct {
    vec_req_t req;
    bit       fixed;
    vec_res_t res;
  } dir_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [159:0] s_tdata = '0;
  logic [2:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [95:0]  m_tdata;
  logic [1:0]   m_tuser;

  vec_res_t pending_results[$];
  int       errors = 0;
  bit       feed_done = 1'b0;
  bit       hold_off = 1'b0;
  longint   cycles = 0;

  vector2d_arith_unit dut (.*);

  always #6 clk = ~clk;

  function automatic longint clamp_s32(longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Product scaled down, rounding toward minus infinity (arithmetic shift does that).
  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b;
    return p >>> FB;
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] n);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint norm_comp(longint c, logic [63:0] len);
    logic [63:0] mag_c, q;
    mag_c = c < 0 ? -c : c;
    q = (mag_c << FB) / len;
    return c < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic vec_res_t predict_vector(vec_req_t r);
    vec_res_t o;
    bit sat;
    longint ax, ay, bx, by, f, rx, ry;
    logic [63:0] ux, uy, mag;
    ax = r.a_x; ay = r.a_y; bx = r.b_x; by = r.b_y; f = r.factor;
    sat = 0; rx = 0; ry = 0; mag = 0;
    o = '0;
    case (r.op)
      OP_ADD: begin
        rx = clamp_s32(ax + bx, sat);
        ry = clamp_s32(ay + by, sat);
      end
      OP_SUB: begin
        rx = clamp_s32(ax - bx, sat);
        ry = clamp_s32(ay - by, sat);
      end
      OP_SCALE: begin
        rx = clamp_s32(qmul(ax, f), sat);
        ry = clamp_s32(qmul(ay, f), sat);
      end
      OP_LENGTH, OP_NORM: begin
        ux = ax < 0 ? -ax : ax;
        uy = ay < 0 ? -ay : ay;
        mag = isqrt(ux * ux + uy * uy);
        if (r.op == OP_NORM) begin
          if (mag == 0) begin
            o.zero_length = 1'b1;
          end else begin
            rx = norm_comp(ax, mag);
            ry = norm_comp(ay, mag);
          end
        end
      end
      default: ;
    endcase
    o.r_x = rx[31:0];
    o.r_y = ry[31:0];
    o.magnitude = mag[31:0];
    o.saturated = sat;
    return o;
  endfunction

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 1) ? 32'd0 : 32'hffffffff;
      3: return {{16{1'b0}}, 16'($urandom)} - 32'h8000;
      4: return {{8{1'b0}}, 24'($urandom)} - 32'h800000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(vec_req_t r, bit fixed, vec_res_t res);
    if (fixed) pending_results.push_back(res);
    else pending_results.push_back(predict_vector(r));
    s_tdata <= {r.factor, r.b_y, r.b_x, r.a_y, r.a_x};
    s_tuser <= r.op;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Sender: directed table, then random bursts with gaps.
  initial begin
    dir_row_t rows[$];
    vec_req_t r;
    int burst;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    rows.push_back('{'{OP_ADD, 32'h7fffffff, 32'h80000000, 32'd1, 32'hffffffff, 0}, 1,
                     '{32'h7fffffff, 32'h80000000, 0, 1, 0}});
    rows.push_back('{'{OP_SUB, 32'h80000000, 32'h7fffffff, 32'd1, 32'hffffffff, 0}, 1,
                     '{32'h80000000, 32'h7fffffff, 0, 1, 0}});
    rows.push_back('{'{OP_ADD, 32'd5, 32'd7, 32'd3, 32'hfffffffe, 0}, 1,
                     '{32'd8, 32'd5, 0, 0, 0}});
    rows.push_back('{'{OP_NORM, 0, 0, 32'hffffffff, 32'hffffffff, 32'hffffffff}, 1,
                     '{0, 0, 0, 0, 1}});
    rows.push_back('{'{OP_LENGTH, 32'd3, 32'd4, 0, 0, 0}, 1, '{0, 0, 32'd5, 0, 0}});
    rows.push_back('{'{3'd5, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                     32'hffffffff}, 1, '{0, 0, 0, 0, 0}});
    rows.push_back('{'{3'd7, 32'h1234, 32'h5678, 1, 2, 3}, 1, '{0, 0, 0, 0, 0}});
    rows.push_back('{'{3'd6, 32'h80000000, 1, 2, 3, 4}, 1, '{0, 0, 0, 0, 0}});
    rows.push_back('{'{OP_SCALE, 32'h7fffffff, 32'h80000000, 0, 0, 32'h7fffffff}, 0, '0});
    rows.push_back('{'{OP_SCALE, 32'h80000000, 32'h80000000, 0, 0, 32'h80000000}, 0, '0});
    rows.push_back('{'{OP_SCALE, 32'hffffffff, 32'd1, 0, 0, 32'hffffffff}, 0, '0});
    rows.push_back('{'{OP_SCALE, 32'h00030000, 32'hfffd0000, 0, 0, 32'h00008000}, 0, '0});
    rows.push_back('{'{OP_LENGTH, 32'h80000000, 32'h80000000, 0, 0, 0}, 0, '0});
    rows.push_back('{'{OP_LENGTH, 32'h7fffffff, 32'h80000000, 0, 0, 0}, 0, '0});
    rows.push_back('{'{OP_NORM, 32'h80000000, 32'h80000000, 0, 0, 0}, 0, '0});
    rows.push_back('{'{OP_NORM, 32'h7fffffff, 0, 0, 0, 0}, 0, '0});
    rows.push_back('{'{OP_NORM, 32'd1, 32'hffffffff, 0, 0, 0}, 0, '0});
    rows.push_back('{'{OP_NORM, 0, 32'h80000000, 0, 0, 0}, 0, '0});
    rows.push_back('{'{OP_SUB, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 0}, 0, '0});
    foreach (rows[i]) begin
      @(negedge clk);
      send_request(rows[i].req, rows[i].fixed, rows[i].res);
    end
    for (int n = 0; n < N_RANDOM; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < N_RANDOM; k++, n++) begin
        r.op = $urandom_range(0, 15) == 0 ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        r.a_x = rand_comp();
        r.a_y = rand_comp();
        r.b_x = rand_comp();
        r.b_y = rand_comp();
        r.factor = rand_comp();
        @(negedge clk);
        send_request(r, 0, '0);
      end
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b0;
    feed_done = 1'b1;
  end

  // Long hold-off once the random part is well underway so the pipeline backs up.
  initial begin
    wait (!rst);
    repeat (600) @(posedge clk);
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
  end

  // Receiver: its own stall pattern, with quiet stretches.
  initial begin
    int mode;
    mode = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      if (hold_off) m_tready <= 1'b0;
      else if (mode == 0) m_tready <= 1'b1;
      else if (mode == 1) m_tready <= $urandom_range(0, 3) != 0;
      else m_tready <= $urandom_range(0, 3) == 0;
    end
  end

  always @(posedge clk) begin
    vec_res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser[0], m_tuser[1]};
      if (pending_results.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.r_x !== want.r_x) begin
          $error("r_x expected %h actual %h", want.r_x, got.r_x); errors++;
        end
        if (got.r_y !== want.r_y) begin
          $error("r_y expected %h actual %h", want.r_y, got.r_y); errors++;
        end
        if (got.magnitude !== want.magnitude) begin
          $error("magnitude expected %h actual %h", want.magnitude, got.magnitude); errors++;
        end
        if (got.saturated !== want.saturated) begin
          $error("saturated expected %b actual %b", want.saturated, got.saturated); errors++;
        end
        if (got.zero_length !== want.zero_length) begin
          $error("zero_length expected %b actual %b", want.zero_length, got.zero_length);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("vector2d_arith_unit: mismatch");
      $finish;
    end
  end

  initial begin
    wait (feed_done);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("vector2d_arith_unit: match");
    end else begin
      $display("vector2d_arith_unit: mismatch");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/v2d_pkg.sv
rtl/v2d_front.sv
rtl/v2d_queue.sv
rtl/v2d_back.sv
rtl/vector2d_arith_unit.sv
verif/vector2d_arith_unit_test.sv
